@@ sv/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_POP_EMPTY,
        STATUS_PUSH_FULL
    } status_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FILL_W = 5;

    typedef struct packed {
        cmd_t                      command;
        logic signed [DATA_W-1:0]  push_value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        status_t                   status;
        logic        [FILL_W-1:0]  fill_count;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic load_direct;
        logic load_read;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic empty;
    } stat_t;

endpackage

@@ sv/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/deq_datapath.sv @@
// ----------------------------------------------------------------------------
// deq_datapath
// ring pointers, entry storage and result register
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  deq_pkg::in_t    in_data,
    input  deq_pkg::ctrl_t  ctrl,
    output deq_pkg::stat_t  stat,
    output deq_pkg::out_t   out_data
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    deq_pkg::out_t    out_reg;

    logic             full;
    logic             empty;
    logic             is_pop;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] last_slot;
    logic [IDX_W:0]   sum_back;
    logic [IDX_W:0]   sum_last;
    logic [IDX_W:0]   sum_inc;
    logic [deq_pkg::DATA_W-1:0] rd_data;
    deq_pkg::status_t status_now;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign is_pop = (in_data.command == deq_pkg::CMD_POP_FRONT)
                 || (in_data.command == deq_pkg::CMD_POP_BACK);

    // ring arithmetic on the front index, which stays below capacity
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign sum_inc   = {1'b0, front_reg} + (IDX_W+1)'(1);
    assign front_inc = (sum_inc >= (IDX_W+1)'(CAPACITY))
                     ? IDX_W'(sum_inc - (IDX_W+1)'(CAPACITY)) : IDX_W'(sum_inc);
    assign sum_back  = {1'b0, front_reg} + (IDX_W+1)'(count_reg);
    assign back_slot = (sum_back >= (IDX_W+1)'(CAPACITY))
                     ? IDX_W'(sum_back - (IDX_W+1)'(CAPACITY)) : IDX_W'(sum_back);
    assign sum_last  = {1'b0, front_reg} + (IDX_W+1)'(count_reg - 1'b1);
    assign last_slot = (sum_last >= (IDX_W+1)'(CAPACITY))
                     ? IDX_W'(sum_last - (IDX_W+1)'(CAPACITY)) : IDX_W'(sum_last);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        addr       = front_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        status_now = deq_pkg::STATUS_DONE;
        case (in_data.command)
            deq_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_now = deq_pkg::STATUS_PUSH_FULL;
                end
                else
                begin
                    addr       = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_now = deq_pkg::STATUS_PUSH_FULL;
                end
                else
                begin
                    addr       = back_slot;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_now = deq_pkg::STATUS_POP_EMPTY;
                end
                else
                begin
                    addr       = front_reg;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                    rd_en      = 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_now = deq_pkg::STATUS_POP_EMPTY;
                end
                else
                begin
                    addr       = last_slot;
                    count_next = count_reg - 1'b1;
                    rd_en      = 1'b1;
                end
            end
            default:
            begin
                status_now = deq_pkg::STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_direct)
        begin
            out_reg.popped_value <= '0;
            out_reg.status       <= status_now;
            out_reg.fill_count   <= deq_pkg::FILL_W'(count_next);
        end
        else if (ctrl.load_read)
        begin
            out_reg.popped_value <= rd_data;
            out_reg.status       <= deq_pkg::STATUS_DONE;
            out_reg.fill_count   <= deq_pkg::FILL_W'(count_reg);
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (2 ** IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.exec && wr_en),
        .waddr (addr),
        .wdata (in_data.push_value),
        .re    (ctrl.exec && rd_en),
        .raddr (addr),
        .rdata (rd_data)
    );

    assign stat.is_pop = is_pop;
    assign stat.empty  = empty;
    assign out_data    = out_reg;

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("entry count above capacity");

    property p_front_bound;
        @(posedge clk) disable iff (!rst_n)
        {1'b0, front_reg} < (IDX_W+1)'(CAPACITY);
    endproperty
    a_front_bound: assert property (p_front_bound)
        else $error("front index out of ring");

    property p_push_grows;
        @(posedge clk) disable iff (!rst_n)
        (ctrl.exec && wr_en) |=> (count_reg == $past(count_reg) + 1'b1);
    endproperty
    a_push_grows: assert property (p_push_grows)
        else $error("push did not grow count");

endmodule

@@ sv/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// request sequencing and result handshake
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  deq_pkg::stat_t  stat,
    output deq_pkg::ctrl_t  ctrl
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   pop_ok;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign pop_ok   = stat.is_pop && !stat.empty;

    assign ctrl.exec        = accept;
    assign ctrl.load_direct = accept && !pop_ok;
    assign ctrl.load_read   = (state_reg == S_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && pop_ok)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (ctrl.load_direct || ctrl.load_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    property p_read_slot_free;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg;
    endproperty
    a_read_slot_free: assert property (p_read_slot_free)
        else $error("result register busy during ram read");

    property p_single_load;
        @(posedge clk) disable iff (!rst_n)
        !(ctrl.load_direct && ctrl.load_read);
    endproperty
    a_single_load: assert property (p_single_load)
        else $error("two result loads at once");

    property p_pop_blocks;
        @(posedge clk) disable iff (!rst_n)
        (accept && pop_ok) |=> (!in_ready && ctrl.load_read);
    endproperty
    a_pop_blocks: assert property (p_pop_blocks)
        else $error("pop read not followed by result load");

endmodule

@@ sv/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// fixed-capacity double-ended queue of signed 32-bit words
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_ready / in_data carry one request, a command
//   (push front, push back, pop front, pop back) and a push value
//   out channel: out_valid / out_ready / out_data carry one result per
//   request: popped value, status and fill count after the request
//   push and error requests: result registered at acceptance and shown in
//   the cycle after; with out_ready high, one request per cycle is accepted
//   successful pop: the ram read is registered, then the result is loaded in
//   the read state; no new request is taken until that result is loaded
//   a full push or an empty pop leaves the queue unchanged and reports it
//   in status with a zero popped value
//   reset clears the front pointer and the count; ram contents stay as is
//   while out_ready is low the result register holds and in_ready drops
//   until the result is taken
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  deq_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output deq_pkg::out_t  out_data
);

    deq_pkg::ctrl_t ctrl;
    deq_pkg::stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .ctrl     (ctrl),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking regression for the fixed-capacity double-ended queue
//
// a ring-buffer predictor tracks the front position, the count and the
// stored words, and works out the popped value, status and fill count of
// every accepted request. Results are matched in order against those
// predictions. The tests cover edge values, fill and drain past the ring
// wrap, refused pushes and empty pops, back-to-back streaming, a long
// receiver hold-off and a long random mix that swings between empty and full
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_SPAN      = 300;
    localparam int STREAM_ITEMS   = 150;
    localparam int HOLD_ITEMS     = 60;
    localparam int RANDOM_ITEMS   = 950;
    localparam int DRAIN_CYCLES   = 10;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    deq_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    deq_pkg::out_t out_data;

    // predictor state
    logic signed [deq_pkg::DATA_W-1:0] deq_store [DEPTH];
    int unsigned deq_front;
    int unsigned deq_count;
    deq_pkg::out_t expected_results [$];
    deq_pkg::out_t oldest_expected;

    bit quiet_mode;
    bit hold_pending;
    bit ready_calm;
    int hold_left;

    int mismatch_count;
    int results_checked;
    int idle_cycles;
    int refused_pushes;
    int empty_pops;
    int cmd_tally [4];

    double_ended_queue #(
        .CAPACITY(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void predict_result(input deq_pkg::in_t req);
        deq_pkg::out_t res;
        res.popped_value = '0;
        res.status = deq_pkg::STATUS_DONE;
        case (req.command)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK:
            begin
                if (deq_count == DEPTH)
                begin
                    res.status = deq_pkg::STATUS_PUSH_FULL;
                    refused_pushes++;
                end
                else if (req.command == deq_pkg::CMD_PUSH_FRONT)
                begin
                    deq_front = (deq_front + DEPTH - 1) % DEPTH;
                    deq_store[deq_front] = req.push_value;
                    deq_count++;
                end
                else
                begin
                    deq_store[(deq_front + deq_count) % DEPTH] = req.push_value;
                    deq_count++;
                end
            end
            default:
            begin
                if (deq_count == 0)
                begin
                    res.status = deq_pkg::STATUS_POP_EMPTY;
                    empty_pops++;
                end
                else if (req.command == deq_pkg::CMD_POP_FRONT)
                begin
                    res.popped_value = deq_store[deq_front];
                    deq_front = (deq_front + 1) % DEPTH;
                    deq_count--;
                end
                else
                begin
                    res.popped_value = deq_store[(deq_front + deq_count - 1) % DEPTH];
                    deq_count--;
                end
            end
        endcase
        res.fill_count = deq_pkg::FILL_W'(deq_count);
        expected_results.push_back(res);
    endfunction

    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
        logic signed [deq_pkg::DATA_W-1:0] val;
        val = $urandom;
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: val = 32'sh7FFF_FFFF;
                1: val = 32'sh8000_0000;
                2: val = '0;
                default: val = '1;
            endcase
        end
        return val;
    endfunction

    // drive one request, hold it until taken, then predict its result
    task automatic send_request(input deq_pkg::cmd_t command,
                                input logic signed [deq_pkg::DATA_W-1:0] value);
        if (!quiet_mode)
        begin
            while ($urandom_range(99) < 10)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_data.command = command;
        in_data.push_value = value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_result(in_data);
        cmd_tally[command]++;
        @(negedge clk);
    endtask

    task automatic random_request(input int push_pct);
        bit is_push;
        bit at_back;
        deq_pkg::cmd_t command;
        is_push = $urandom_range(99) < push_pct;
        at_back = 1'($urandom_range(1));
        if (is_push)
            command = at_back ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        else
            command = at_back ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
        send_request(command, pick_value());
    endtask

    task automatic test_edge_values();
        send_request(deq_pkg::CMD_POP_FRONT, 32'sh1234_5678);
        send_request(deq_pkg::CMD_POP_BACK, '1);
        send_request(deq_pkg::CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(deq_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
        send_request(deq_pkg::CMD_PUSH_FRONT, '0);
        send_request(deq_pkg::CMD_PUSH_BACK, '1);
        send_request(deq_pkg::CMD_PUSH_FRONT, 32'sh5555_5555);
        send_request(deq_pkg::CMD_PUSH_BACK, 32'shAAAA_AAAA);
        send_request(deq_pkg::CMD_POP_BACK, '0);
        send_request(deq_pkg::CMD_POP_FRONT, '1);
        send_request(deq_pkg::CMD_POP_BACK, 32'sh5555_5555);
        send_request(deq_pkg::CMD_POP_FRONT, 32'shAAAA_AAAA);
        send_request(deq_pkg::CMD_POP_FRONT, '0);
        send_request(deq_pkg::CMD_POP_BACK, '0);
        send_request(deq_pkg::CMD_POP_BACK, '0);
    endtask

    // two rounds, the second starting from a shifted front position
    task automatic test_fill_and_drain();
        for (int round = 0; round < 2; round++)
        begin
            while (deq_count < DEPTH)
                random_request(100);
            send_request(deq_pkg::CMD_PUSH_FRONT, pick_value());
            send_request(deq_pkg::CMD_PUSH_BACK, pick_value());
            while (deq_count > 0)
                random_request(0);
            send_request(deq_pkg::CMD_POP_FRONT, pick_value());
            send_request(deq_pkg::CMD_PUSH_BACK, pick_value());
            send_request(deq_pkg::CMD_PUSH_BACK, pick_value());
            send_request(deq_pkg::CMD_POP_FRONT, pick_value());
            send_request(deq_pkg::CMD_POP_FRONT, pick_value());
        end
    endtask

    task automatic test_streaming();
        quiet_mode = 1'b1;
        for (int i = 0; i < STREAM_ITEMS; i++)
            random_request(deq_count < DEPTH / 2 ? 70 : 30);
        quiet_mode = 1'b0;
    endtask

    // receiver stops while requests keep coming, so the input stalls
    task automatic test_receiver_hold();
        quiet_mode = 1'b1;
        hold_pending = 1'b1;
        for (int i = 0; i < HOLD_ITEMS; i++)
            random_request(60);
        quiet_mode = 1'b0;
    endtask

    // phases lean toward filling, draining or neither
    task automatic test_random_mix();
        int push_pct;
        int phase_left;
        phase_left = 0;
        push_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            phase_left--;
            random_request(push_pct);
        end
    endtask

    task automatic note_mismatch(input string field,
                                 input logic [deq_pkg::DATA_W-1:0] want,
                                 input logic [deq_pkg::DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     field, results_checked, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                note_mismatch("unexpected result", '0, out_data.popped_value);
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (out_data.popped_value !== oldest_expected.popped_value)
                    note_mismatch("popped value", oldest_expected.popped_value,
                                  out_data.popped_value);
                if (out_data.status !== oldest_expected.status)
                    note_mismatch("status", deq_pkg::DATA_W'(oldest_expected.status),
                                  deq_pkg::DATA_W'(out_data.status));
                if (out_data.fill_count !== oldest_expected.fill_count)
                    note_mismatch("fill count",
                                  deq_pkg::DATA_W'(oldest_expected.fill_count),
                                  deq_pkg::DATA_W'(out_data.fill_count));
            end
            results_checked++;
        end
    end

    // receiver side, with an optional long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left = HOLD_SPAN;
            end
            ready_calm = quiet_mode;
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ready_calm || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("double_ended_queue regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        quiet_mode = 1'b0;
        hold_pending = 1'b0;
        deq_front = 0;
        deq_count = 0;
        mismatch_count = 0;
        results_checked = 0;
        idle_cycles = 0;
        refused_pushes = 0;
        empty_pops = 0;
        cmd_tally = '{default: 0};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_edge_values();
        test_fill_and_drain();
        test_streaming();
        test_receiver_hold();
        test_random_mix();
        in_valid = 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d push front, %0d push back, %0d pop front, %0d pop back requests",
                 cmd_tally[deq_pkg::CMD_PUSH_FRONT], cmd_tally[deq_pkg::CMD_PUSH_BACK],
                 cmd_tally[deq_pkg::CMD_POP_FRONT], cmd_tally[deq_pkg::CMD_POP_BACK]);
        $display("%0d results checked, %0d refused full pushes, %0d empty pops, %0d mismatches",
                 results_checked, refused_pushes, empty_pops, mismatch_count);
        if (mismatch_count == 0)
            $display("double_ended_queue regression: pass");
        else
            $display("double_ended_queue regression: fail");
        $finish;
    end

endmodule
